[rtl/core/bus_sync_state_tracker_assert.svh]
// Assertion macros used by the tracker RTL.
`ifndef BUS_SYNC_STATE_TRACKER_ASSERT_SVH
`define BUS_SYNC_STATE_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BSST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

[rtl/core/bsst_pkg.sv]
`timescale 1ns / 1ps

package bsst_pkg;

  localparam int unsigned StateW = 3;
  localparam int unsigned SuperW = 2;
  localparam int unsigned EventW = 2;

  // Sync state codes.
  localparam logic [StateW-1:0] ST_BOOTSTRAP = 3'd0;
  localparam logic [StateW-1:0] ST_QSYNCED   = 3'd1;
  localparam logic [StateW-1:0] ST_SYNCED    = 3'd2;
  localparam logic [StateW-1:0] ST_SYNCED2   = 3'd3;
  localparam logic [StateW-1:0] ST_MISSED    = 3'd4;
  localparam logic [StateW-1:0] ST_UNSYNCED  = 3'd5;
  localparam logic [StateW-1:0] ST_UNSYNCED2 = 3'd6;
  localparam logic [StateW-1:0] ST_UNUSED    = 3'd7;

  // Superstate codes.
  localparam logic [SuperW-1:0] SUP_BOOTSTRAP = 2'd0;
  localparam logic [SuperW-1:0] SUP_RUNNING   = 2'd1;
  localparam logic [SuperW-1:0] SUP_SUSPENDED = 2'd2;

  // Slot events.
  localparam logic [EventW-1:0] EV_FIRST  = 2'd0;
  localparam logic [EventW-1:0] EV_SECOND = 2'd1;
  localparam logic [EventW-1:0] EV_MISS   = 2'd2;

  // Round kinds.
  localparam logic RK_MAIN     = 1'b0;
  localparam logic RK_SCHEDULE = 1'b1;

  typedef struct packed {
    logic        control_received;
    logic        first_schedule;
    logic [31:0] rx_time;
    logic [15:0] rx_period;
    logic [63:0] ref_timestamp;
  } bsst_in_t;

  typedef struct packed {
    logic [StateW-1:0] sync_state_out;
    logic [SuperW-1:0] superstate;
    logic              round_kind;
    logic [31:0]       sched_time_out;
    logic [15:0]       sched_period_out;
    logic [31:0]       sync_time_out;
    logic [63:0]       sync_stamp_out;
    logic              proc_enable;
  } bsst_out_t;

  // Next sync state. Undefined transitions and the unused code fall back
  // to the behavior of bootstrap.
  function automatic logic [StateW-1:0] sync_step(input logic [EventW-1:0] ev,
                                                  input logic [StateW-1:0] st);
    logic [StateW-1:0] nxt;
    nxt = ST_BOOTSTRAP;
    case (ev)
      EV_FIRST: begin
        case (st)
          ST_BOOTSTRAP: nxt = ST_QSYNCED;
          ST_QSYNCED:   nxt = ST_SYNCED;
          ST_SYNCED2:   nxt = ST_SYNCED;
          ST_MISSED:    nxt = ST_SYNCED;
          ST_UNSYNCED2: nxt = ST_SYNCED;
          ST_UNUSED:    nxt = ST_QSYNCED;
          default:      nxt = ST_BOOTSTRAP;
        endcase
      end
      EV_SECOND: begin
        case (st)
          ST_QSYNCED:  nxt = ST_QSYNCED;
          ST_SYNCED:   nxt = ST_SYNCED2;
          ST_UNSYNCED: nxt = ST_SYNCED2;
          default:     nxt = ST_BOOTSTRAP;
        endcase
      end
      EV_MISS: begin
        case (st)
          ST_SYNCED:   nxt = ST_MISSED;
          ST_SYNCED2:  nxt = ST_UNSYNCED;
          ST_MISSED:   nxt = ST_UNSYNCED;
          ST_UNSYNCED: nxt = ST_UNSYNCED2;
          default:     nxt = ST_BOOTSTRAP;
        endcase
      end
      default: nxt = ST_BOOTSTRAP;
    endcase
    return nxt;
  endfunction

  function automatic logic [SuperW-1:0] super_of(input logic [StateW-1:0] st);
    logic [SuperW-1:0] sup;
    case (st)
      ST_QSYNCED:   sup = SUP_SUSPENDED;
      ST_SYNCED:    sup = SUP_RUNNING;
      ST_SYNCED2:   sup = SUP_SUSPENDED;
      ST_MISSED:    sup = SUP_SUSPENDED;
      ST_UNSYNCED:  sup = SUP_RUNNING;
      ST_UNSYNCED2: sup = SUP_SUSPENDED;
      default:      sup = SUP_BOOTSTRAP;
    endcase
    return sup;
  endfunction

endpackage

[rtl/core/bus_sync_state_tracker.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-------------------
// in       | input     | in_valid_i / in_ready_o  | in_i  (bsst_in_t)
// out      | output    | out_valid_o / out_ready_i| out_o (bsst_out_t)
//
// Each transaction passes an input register and a result register. Its
// result becomes valid as it moves from the input register into the
// result register; a stalled output can hold it in the input register.
// While out_ready_i stays high, one transaction per cycle is sustained;
// the tracker state updates as a transaction enters the result register.
// Reset clears the state, the period history and both valid flags.
// A stalled output holds the result; the input register still takes one
// more transaction, after which in_ready_o follows out_ready_i.

`include "bus_sync_state_tracker_assert.svh"

module bus_sync_state_tracker
  import bsst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bsst_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bsst_out_t out_o
);

  // Input register.
  logic     in_valid_q;
  bsst_in_t in_q;

  // Result register.
  logic      out_valid_q;
  bsst_out_t out_q;

  // Tracker state.
  logic [StateW-1:0] sync_state_q, sync_state_d;
  logic              round_kind_q, round_kind_d;
  logic [31:0]       sched_time_q, sched_time_d;
  logic [15:0]       sched_period_q, sched_period_d;
  logic [15:0]       hist0_q, hist1_q;
  logic [31:0]       sync_time_q, sync_time_d;
  logic [63:0]       sync_stamp_q, sync_stamp_d;

  logic              out_free;
  logic              advance;
  logic [EventW-1:0] slot_event;
  bsst_out_t         out_d;

  // The result register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  // Classify the slot and compute the updated schedule and sync point.
  always_comb begin
    slot_event     = EV_MISS;
    round_kind_d   = ~round_kind_q;
    sched_time_d   = sched_time_q + 32'(sched_period_q);
    sched_period_d = hist1_q;
    sync_time_d    = sync_time_q;
    sync_stamp_d   = sync_stamp_q;
    if (in_q.control_received) begin
      sched_time_d   = in_q.rx_time;
      sched_period_d = in_q.rx_period;
      if (in_q.first_schedule) begin
        slot_event   = EV_FIRST;
        round_kind_d = RK_MAIN;
        sync_time_d  = in_q.rx_time;
        sync_stamp_d = in_q.ref_timestamp;
      end else begin
        slot_event   = EV_SECOND;
        round_kind_d = RK_SCHEDULE;
      end
    end
    sync_state_d = sync_step(slot_event, sync_state_q);

    out_d.sync_state_out   = sync_state_d;
    out_d.superstate       = super_of(sync_state_d);
    out_d.round_kind       = round_kind_d;
    out_d.sched_time_out   = sched_time_d;
    out_d.sched_period_out = sched_period_d;
    out_d.sync_time_out    = sync_time_d;
    out_d.sync_stamp_out   = sync_stamp_d;
    // Pre and post processing run when the current round is schedule-only.
    out_d.proc_enable      = round_kind_d;
  end

  // Handshake control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Tracker state, updated once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_state_q   <= ST_BOOTSTRAP;
      round_kind_q   <= RK_MAIN;
      sched_time_q   <= '0;
      sched_period_q <= '0;
      hist0_q        <= '0;
      hist1_q        <= '0;
      sync_time_q    <= '0;
      sync_stamp_q   <= '0;
    end else if (advance) begin
      sync_state_q   <= sync_state_d;
      round_kind_q   <= round_kind_d;
      sched_time_q   <= sched_time_d;
      sched_period_q <= sched_period_d;
      hist1_q        <= hist0_q;
      hist0_q        <= sched_period_d;
      sync_time_q    <= sync_time_d;
      sync_stamp_q   <= sync_stamp_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The unused state code is never reached from reset.
  `BSST_ASSERT_NOW(a_state_code, clk_i, rst_ni, 1'b1, sync_state_q != ST_UNUSED)
  // A pending result always reflects the current tracker state.
  `BSST_ASSERT_NOW(a_out_matches_state, clk_i, rst_ni, out_valid_q,
                   (out_q.sync_state_out == sync_state_q) &&
                   (out_q.sched_time_out == sched_time_q))
  // A missed slot advances the schedule time by the old period.
  `BSST_ASSERT_NEXT(a_miss_advance, clk_i, rst_ni,
                    advance && !in_q.control_received,
                    sched_time_q == $past(sched_time_q) + 32'($past(sched_period_q)))
  // A first schedule latches the reference timestamp.
  `BSST_ASSERT_NEXT(a_first_latch, clk_i, rst_ni,
                    advance && in_q.control_received && in_q.first_schedule,
                    sync_stamp_q == $past(in_q.ref_timestamp))

endmodule

[tb/tb_bus_sync_state_tracker.sv]
`timescale 1ns / 1ps

// Testbench for the bus sync state tracker.
//
// Every control slot is sent as one input transaction. At the moment a
// transaction is accepted, a local model of the tracker works out the
// result that the slot must produce. That model covers the sync table,
// the superstate, the round type, the schedule, the period history and
// the sync point. The result goes to the back of a queue. A checker
// compares every output transaction, field by field, against the front
// of that queue.
//
// The stimulus opens with a directed walk through the sync table and a
// few slots at the extremes of the fields. Back-to-back traffic and a
// heavily stalled output follow. The bulk of the run is randomized
// rounds: a first and a second schedule per round, with lost packets,
// bursts of misses and some raw noise slots mixed in. Both channels idle
// at random, and some stretches run without any gaps at all.

module tb_bus_sync_state_tracker;
  import bsst_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  bsst_in_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bsst_out_t res_data;

  bus_sync_state_tracker i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (res_data)
  );

  // 12 ns period. Inputs change on the falling edge, and outputs are
  // sampled on the rising edge.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the tracker state. It is updated once per accepted slot.
  logic [StateW-1:0] trk_state        = ST_BOOTSTRAP;
  logic              trk_round        = RK_MAIN;
  logic [31:0]       trk_sched_time   = '0;
  logic [15:0]       trk_sched_period = '0;
  logic [15:0]       trk_hist0        = '0;
  logic [15:0]       trk_hist1        = '0;
  logic [31:0]       trk_sync_time    = '0;
  logic [63:0]       trk_sync_stamp   = '0;

  // Expected results, oldest first.
  bsst_out_t expected_q[$];

  int  mismatch_cnt = 0;
  int  checked_cnt  = 0;
  int  sent_cnt     = 0;
  int  wrap_cnt     = 0;
  int  slot_cnt [3] = '{0, 0, 0};
  bit  trans_seen [3][8];

  // Pacing knobs: the percentage of transactions preceded by an idle gap,
  // and the chance that the output starts a stall on a given cycle.
  int tx_idle_pct;
  int rx_stall_pct;
  int stall_left = 0;

  // Most gaps are a few cycles long. About one in five is long enough to
  // back the pipeline up completely.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(10, 40));
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = int'($urandom_range(0, 9));
    case (r)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  // Sync table. A transition that the table leaves undefined returns to
  // bootstrap. The unused code behaves like bootstrap itself.
  function automatic logic [StateW-1:0] sync_next(input logic [EventW-1:0] ev,
                                                  input logic [StateW-1:0] st);
    logic [StateW-1:0] nxt;
    nxt = ST_BOOTSTRAP;
    case (st)
      ST_BOOTSTRAP, ST_UNUSED: begin
        if (ev == EV_FIRST) nxt = ST_QSYNCED;
      end
      ST_QSYNCED: begin
        if (ev == EV_FIRST) nxt = ST_SYNCED;
        else if (ev == EV_SECOND) nxt = ST_QSYNCED;
      end
      ST_SYNCED: begin
        if (ev == EV_SECOND) nxt = ST_SYNCED2;
        else if (ev == EV_MISS) nxt = ST_MISSED;
      end
      ST_SYNCED2, ST_MISSED: begin
        if (ev == EV_FIRST) nxt = ST_SYNCED;
        else if (ev == EV_MISS) nxt = ST_UNSYNCED;
      end
      ST_UNSYNCED: begin
        if (ev == EV_SECOND) nxt = ST_SYNCED2;
        else if (ev == EV_MISS) nxt = ST_UNSYNCED2;
      end
      ST_UNSYNCED2: begin
        if (ev == EV_FIRST) nxt = ST_SYNCED;
      end
      default: nxt = ST_BOOTSTRAP;
    endcase
    return nxt;
  endfunction

  function automatic logic [SuperW-1:0] sync_super(input logic [StateW-1:0] st);
    case (st)
      ST_SYNCED, ST_UNSYNCED:                           return SUP_RUNNING;
      ST_QSYNCED, ST_SYNCED2, ST_MISSED, ST_UNSYNCED2:  return SUP_SUSPENDED;
      default:                                          return SUP_BOOTSTRAP;
    endcase
  endfunction

  // Applies one control slot to the local state and returns the result
  // that the tracker must report for it.
  function automatic bsst_out_t track_slot(input bsst_in_t s);
    bsst_out_t         r;
    logic [EventW-1:0] ev;
    logic [32:0]       next_time;
    if (s.control_received) begin
      trk_sched_time   = s.rx_time;
      trk_sched_period = s.rx_period;
      if (s.first_schedule) begin
        ev             = EV_FIRST;
        trk_round      = RK_MAIN;
        trk_sync_time  = s.rx_time;
        trk_sync_stamp = s.ref_timestamp;
      end else begin
        ev        = EV_SECOND;
        trk_round = RK_SCHEDULE;
      end
    end else begin
      // A lost schedule is extrapolated: the time moves on by one period,
      // and the period falls back to the one from two slots ago.
      ev        = EV_MISS;
      trk_round = ~trk_round;
      next_time = 33'(trk_sched_time) + 33'(trk_sched_period);
      if (next_time[32]) wrap_cnt++;
      trk_sched_time   = next_time[31:0];
      trk_sched_period = trk_hist1;
    end
    trk_hist1 = trk_hist0;
    trk_hist0 = trk_sched_period;

    trans_seen[ev][trk_state] = 1'b1;
    slot_cnt[ev]++;
    trk_state = sync_next(ev, trk_state);

    r.sync_state_out   = trk_state;
    r.superstate       = sync_super(trk_state);
    r.round_kind       = trk_round;
    r.sched_time_out   = trk_sched_time;
    r.sched_period_out = trk_sched_period;
    r.sync_time_out    = trk_sync_time;
    r.sync_stamp_out   = trk_sync_stamp;
    // Pre and post processing run when the current round is schedule-only.
    r.proc_enable      = trk_round;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      report_mismatch($sformatf("result %0d, %s: expected 0x%0h, actual 0x%0h",
                                checked_cnt, name, exp_v, act_v));
    end
  endtask

  // Output side. A stall is either in progress, starts now, or the
  // channel is ready. Exactly one assignment is made per falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      stall_left = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker. Every output transaction must have an expectation
  // waiting, and it must match that expectation in every field.
  always @(posedge clk) begin : result_checker
    bsst_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no slot pending", checked_cnt));
      end else begin
        want = expected_q.pop_front();
        check_field("sync_state_out", 64'(want.sync_state_out),
                    64'(res_data.sync_state_out));
        check_field("superstate", 64'(want.superstate), 64'(res_data.superstate));
        check_field("round_kind", 64'(want.round_kind), 64'(res_data.round_kind));
        check_field("sched_time_out", 64'(want.sched_time_out),
                    64'(res_data.sched_time_out));
        check_field("sched_period_out", 64'(want.sched_period_out),
                    64'(res_data.sched_period_out));
        check_field("sync_time_out", 64'(want.sync_time_out),
                    64'(res_data.sync_time_out));
        check_field("sync_stamp_out", want.sync_stamp_out, res_data.sync_stamp_out);
        check_field("proc_enable", 64'(want.proc_enable), 64'(res_data.proc_enable));
      end
      checked_cnt++;
    end
  end

  // Sends one slot. The task is entered on a falling edge and returns on
  // the falling edge after acceptance, with valid still high. The next
  // call then either keeps valid up with new data or drops it for a gap.
  task automatic send_slot(input bsst_in_t item);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(track_slot(item));
    sent_cnt++;
    @(negedge clk);
  endtask

  // Builds a slot of the given kind. On a miss the packet fields carry
  // random content, because the tracker has to ignore them.
  task automatic send_fields(input logic [EventW-1:0] ev, input logic [31:0] t,
                             input logic [15:0] p, input logic [63:0] stamp);
    bsst_in_t item;
    item.control_received = (ev != EV_MISS);
    item.first_schedule   = (ev == EV_FIRST);
    item.rx_time          = t;
    item.rx_period        = p;
    item.ref_timestamp    = stamp;
    if (ev == EV_MISS) begin
      item.first_schedule = 1'($urandom);
      item.rx_time        = $urandom;
      item.rx_period      = 16'($urandom);
      item.ref_timestamp  = {$urandom, $urandom};
    end
    send_slot(item);
  endtask

  // Walks from reset through every state and most of the table's edges.
  // That includes the undefined transitions that fall back to bootstrap.
  task automatic test_state_walk();
    logic [EventW-1:0] walk_seq [26];
    logic [31:0]       t;
    logic [15:0]       p;
    logic [63:0]       stamp;
    walk_seq = '{EV_MISS,   EV_SECOND, EV_FIRST,  EV_MISS,   EV_FIRST,  EV_SECOND,
                 EV_FIRST,  EV_FIRST,  EV_FIRST,  EV_FIRST,  EV_SECOND, EV_FIRST,
                 EV_MISS,   EV_FIRST,  EV_MISS,   EV_MISS,   EV_SECOND, EV_MISS,
                 EV_MISS,   EV_FIRST,  EV_SECOND, EV_SECOND, EV_FIRST,  EV_FIRST,
                 EV_MISS,   EV_SECOND};
    for (int i = 0; i < 26; i++) begin
      t     = (i % 4 == 0) ? 32'hFFFF_FFFF : (i % 4 == 1) ? 32'h0 : $urandom;
      p     = (i % 5 == 0) ? 16'hFFFF : (i % 5 == 1) ? 16'h0 : 16'($urandom);
      stamp = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : {$urandom, $urandom};
      send_fields(walk_seq[i], t, p, stamp);
    end
  endtask

  // Field extremes. The schedule time wraps past 2^32 on a miss, the
  // period is recalled from the history, and a miss advances the time by
  // a period of zero.
  task automatic test_field_extremes();
    send_fields(EV_FIRST,  32'hFFFF_FF00, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_fields(EV_SECOND, 32'hFFFF_FFFF, 16'hFFFF, 64'h0);
    send_fields(EV_MISS,   32'h0, 16'h0, 64'h0);
    send_fields(EV_MISS,   32'h0, 16'h0, 64'h0);
    send_fields(EV_FIRST,  32'h0, 16'h0, 64'h0);
    send_fields(EV_SECOND, 32'h0, 16'h0, 64'h0);
    send_fields(EV_MISS,   32'h0, 16'h0, 64'h0);
    send_fields(EV_FIRST,  32'h8000_0000, 16'h8000, 64'h8000_0000_0000_0000);
  endtask

  // Randomized rounds. Most of the traffic is well-formed first/second
  // pairs in which either packet can be lost. Bursts of misses push the
  // table into the unsynced states. Raw slots with random flags break the
  // pattern. With vary set, the pacing changes from stretch to stretch.
  task automatic run_rounds(input int n_items, input bit vary);
    int                start;
    int                pick;
    logic [31:0]       net_t;
    logic [15:0]       per;
    logic [63:0]       stamp;
    logic [EventW-1:0] ev;
    bsst_in_t          raw;
    start = sent_cnt;
    net_t = $urandom;
    per   = pick_period();
    stamp = {$urandom, $urandom};
    while (sent_cnt - start < n_items) begin
      if (vary && $urandom_range(0, 19) == 0) begin
        tx_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(10, 50));
        rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(10, 50));
      end
      if ($urandom_range(0, 9) == 0) per = pick_period();
      pick = int'($urandom_range(0, 19));
      if (pick < 2) begin
        raw.control_received = 1'($urandom);
        raw.first_schedule   = 1'($urandom);
        raw.rx_time          = $urandom;
        raw.rx_period        = 16'($urandom);
        raw.ref_timestamp    = {$urandom, $urandom};
        send_slot(raw);
      end else if (pick < 4) begin
        repeat ($urandom_range(1, 4)) send_fields(EV_MISS, net_t, per, stamp);
      end else begin
        ev = ($urandom_range(0, 99) < 12) ? EV_MISS : EV_FIRST;
        send_fields(ev, net_t, per, stamp);
        stamp = stamp + 64'($urandom_range(1, 100000));
        ev = ($urandom_range(0, 99) < 12) ? EV_MISS : EV_SECOND;
        send_fields(ev, net_t, per, stamp);
        stamp = stamp + 64'($urandom_range(1, 1000000));
        net_t = net_t + 32'(per);
      end
    end
  endtask

  // Full rate on both sides: one transaction per cycle in and out.
  task automatic test_back_to_back();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_rounds(60, 1'b0);
  endtask

  // The sender never idles while the output is stalled often. This fills
  // the pipeline and makes input ready follow output ready.
  task automatic test_output_stall();
    tx_idle_pct  = 0;
    rx_stall_pct = 60;
    run_rounds(60, 1'b0);
  endtask

  task automatic test_random_rounds();
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    run_rounds(560, 1'b1);
  endtask

  initial begin : stimulus
    int covered;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_state_walk();
    test_field_extremes();
    test_back_to_back();
    test_output_stall();
    test_random_rounds();
    in_valid <= 1'b0;

    // Drain the queue, then allow a few cycles in which a stray result
    // would still be caught. The pipeline holds an input and a result register.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    covered = 0;
    for (int e = 0; e < 3; e++) begin
      for (int s = 0; s < 7; s++) covered += int'(trans_seen[e][s]);
    end
    $display("Covered %0d control slots (%0d first, %0d second, %0d lost), %0d results checked.",
             sent_cnt, slot_cnt[EV_FIRST], slot_cnt[EV_SECOND], slot_cnt[EV_MISS],
             checked_cnt);
    $display("Sync table: %0d of 21 state/event pairs reached; schedule time wrapped %0d times.",
             covered, wrap_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog. The slowest legal run, with the longest gap and the longest
  // stall on every transaction, takes about 0.8 ms. This limit allows
  // several times that.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results still expected.", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
